[rtl/core/rx_descriptor_ring_manager_macros.svh]
// Assertion macros shared by the checker files of the receive ring manager.
`ifndef RX_DESCRIPTOR_RING_MANAGER_MACROS_SVH
`define RX_DESCRIPTOR_RING_MANAGER_MACROS_SVH

// Implication checked on every rising edge while reset is released.
`define RDRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdrm assertion failed");

// Condition that must never be seen while reset is released.
`define RDRM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rdrm forbidden condition seen");

`endif

[rtl/core/rdrm_pkg.sv]
`timescale 1ns / 1ps
package rdrm_pkg;

	localparam int RING_DEPTH_DEF = 512;
	localparam int ADDR_W         = 32;
	localparam int WORD_W         = 32;
	localparam int SLOT_W         = 9;
	localparam int LEN_W          = 14;
	localparam int BSIZE_W        = 20;

	localparam logic [BSIZE_W-1:0] BSIZE_RST = 20'd1536;

	localparam int OWN_BIT      = 31;
	localparam int END_RING_BIT = 26;
	// Runt (15), CRC (20), maximum length (21), jabber (22) and length (23) errors.
	localparam logic [WORD_W-1:0] ERR_MASK = 32'h00F0_8000;
	localparam logic [LEN_W-1:0]  CRC_LEN  = 14'd4;

	localparam logic CMD_POST    = 1'b0;
	localparam logic CMD_CONSUME = 1'b1;

	typedef enum logic [2:0] {
		ST_POSTED    = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELIVERED = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_NOT_READY = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// Outcome of one item, handed from the index stage to the result stage.
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  length;
		logic [WORD_W-1:0] size_word;
	} dec_t;

endpackage

[rtl/core/rdrm_ram.sv]
`timescale 1ns / 1ps
module rdrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/rdrm_ctrl.sv]
`timescale 1ns / 1ps
module rdrm_ctrl #(
	parameter int RING_DEPTH = rdrm_pkg::RING_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s1_valid,
	input  logic                            cmd_s1,
	input  logic [rdrm_pkg::ADDR_W-1:0]     baddr_s1,
	input  logic [rdrm_pkg::WORD_W-1:0]     dstat_s1,
	input  logic [rdrm_pkg::BSIZE_W-1:0]    buf_size,
	output logic                            ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]   ram_waddr,
	output logic [rdrm_pkg::ADDR_W-1:0]     ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]   ram_raddr,
	output logic                            s2_valid,
	output rdrm_pkg::dec_t                  dec_s2
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [IDX_W-1:0] prod_q, cons_q, prod_nxt, cons_nxt;
	logic [IDX_W-1:0] prod_inc, cons_inc;
	logic [rdrm_pkg::LEN_W-1:0] len;
	logic drop;
	rdrm_pkg::dec_t dec;

	assign prod_inc = (prod_q == LAST_IDX) ? '0 : prod_q + IDX_W'(1);
	assign cons_inc = (cons_q == LAST_IDX) ? '0 : cons_q + IDX_W'(1);
	assign len      = dstat_s1[rdrm_pkg::LEN_W-1:0];
	assign drop     = (len < rdrm_pkg::CRC_LEN) || (|(dstat_s1 & rdrm_pkg::ERR_MASK));

	assign ram_waddr = prod_q;
	assign ram_wdata = baddr_s1;
	assign ram_raddr = cons_q;

	always_comb begin
		prod_nxt      = prod_q;
		cons_nxt      = cons_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		dec.status    = rdrm_pkg::ST_POSTED;
		dec.slot      = rdrm_pkg::SLOT_W'(prod_q);
		dec.length    = '0;
		dec.size_word = '0;
		unique case (cmd_s1)
			rdrm_pkg::CMD_POST: begin
				if (prod_inc == cons_q) begin
					dec.status = rdrm_pkg::ST_FULL;
				end else begin
					ram_we        = s1_valid;
					prod_nxt      = prod_inc;
					dec.size_word = rdrm_pkg::WORD_W'(buf_size);
					dec.size_word[rdrm_pkg::END_RING_BIT] = (prod_q == LAST_IDX);
				end
			end
			rdrm_pkg::CMD_CONSUME: begin
				dec.slot = rdrm_pkg::SLOT_W'(cons_q);
				if (dstat_s1[rdrm_pkg::OWN_BIT]) begin
					dec.status = rdrm_pkg::ST_NOT_READY;
				end else if (prod_q == cons_q) begin
					dec.status = rdrm_pkg::ST_EMPTY;
				end else begin
					ram_re   = s1_valid;
					cons_nxt = cons_inc;
					if (drop) begin
						dec.status = rdrm_pkg::ST_DROPPED;
					end else begin
						dec.status = rdrm_pkg::ST_DELIVERED;
						dec.length = len - rdrm_pkg::CRC_LEN;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q   <= '0;
			cons_q   <= '0;
			s2_valid <= 1'b0;
		end else begin
			s2_valid <= s1_valid;
			if (s1_valid) begin
				prod_q <= prod_nxt;
				cons_q <= cons_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		dec_s2 <= dec;
	end

endmodule

[rtl/core/rdrm_out.sv]
`timescale 1ns / 1ps
module rdrm_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s2_valid,
	input  rdrm_pkg::dec_t               dec_s2,
	input  logic [rdrm_pkg::ADDR_W-1:0]  ram_rdata,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [rdrm_pkg::SLOT_W-1:0]  slot,
	output logic [rdrm_pkg::ADDR_W-1:0]  frame_address,
	output logic [rdrm_pkg::LEN_W-1:0]   frame_length,
	output logic [rdrm_pkg::WORD_W-1:0]  size_word
);

	logic done_q;
	logic [2:0] status_q;
	logic [rdrm_pkg::SLOT_W-1:0] slot_q;
	logic [rdrm_pkg::ADDR_W-1:0] faddr_q;
	logic [rdrm_pkg::LEN_W-1:0] flen_q;
	logic [rdrm_pkg::WORD_W-1:0] size_q;
	logic has_addr;

	// Only a consumed slot carries its stored address.
	assign has_addr = (dec_s2.status == rdrm_pkg::ST_DELIVERED) ||
		(dec_s2.status == rdrm_pkg::ST_DROPPED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= dec_s2.status;
		slot_q   <= dec_s2.slot;
		faddr_q  <= has_addr ? ram_rdata : '0;
		flen_q   <= dec_s2.length;
		size_q   <= dec_s2.size_word;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign frame_address = faddr_q;
	assign frame_length  = flen_q;
	assign size_word     = size_q;

endmodule

[rtl/core/rx_descriptor_ring_manager.sv]
`timescale 1ns / 1ps
// Channel    Handshake                  Payload
// command    start, busy                command, buffer_address, desc_status
// result     done (one-cycle strobe)    status, slot, frame_address, frame_length, size_word
// config     cfg_valid, cfg_ready       cfg_data (buffer size)
//
// An item is taken on every clock edge at which start is high; busy stays low, so one item
// may follow another in every cycle. Its result passes the item registers, then the index
// stage together with the registered read of the address memory, then the output register.
// Reset clears both ring indices, the pipeline valid flags and sets the buffer size to 1536;
// the address memory is not cleared. The receiver cannot stall, so the pipeline never holds.
module rx_descriptor_ring_manager #(
	parameter int RING_DEPTH = rdrm_pkg::RING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [rdrm_pkg::ADDR_W-1:0]  buffer_address,
	input  logic [rdrm_pkg::WORD_W-1:0]  desc_status,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [rdrm_pkg::SLOT_W-1:0]  slot,
	output logic [rdrm_pkg::ADDR_W-1:0]  frame_address,
	output logic [rdrm_pkg::LEN_W-1:0]   frame_length,
	output logic [rdrm_pkg::WORD_W-1:0]  size_word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rdrm_pkg::BSIZE_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(RING_DEPTH);

	// The item registers form the first stage. Each item changes the ring indices
	// in the stage in which it sits, and the next item sees the updated indices in
	// the following cycle, so no two accesses to the address memory ever overlap.
	logic s1_valid;
	logic cmd_s1;
	logic [rdrm_pkg::ADDR_W-1:0] baddr_s1;
	logic [rdrm_pkg::WORD_W-1:0] dstat_s1;
	logic [rdrm_pkg::BSIZE_W-1:0] buf_size_q;

	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [rdrm_pkg::ADDR_W-1:0] ram_wdata, ram_rdata;
	logic s2_valid;
	rdrm_pkg::dec_t dec_s2;

	// There is never a reason to refuse an item or a register write.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			buf_size_q <= rdrm_pkg::BSIZE_RST;
		end else begin
			s1_valid <= start && !busy;
			if (cfg_valid && cfg_ready) begin
				buf_size_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= command;
			baddr_s1 <= buffer_address;
			dstat_s1 <= desc_status;
		end
	end

	// Ring indices and the decision for each item.
	rdrm_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.cmd_s1   (cmd_s1),
		.baddr_s1 (baddr_s1),
		.dstat_s1 (dstat_s1),
		.buf_size (buf_size_q),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.s2_valid (s2_valid),
		.dec_s2   (dec_s2)
	);

	// One buffer address per ring slot. A slot is only read once it has been posted.
	rdrm_ram #(
		.WIDTH(rdrm_pkg::ADDR_W),
		.DEPTH(RING_DEPTH)
	) u_addr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register: merges the decision with the address read from memory.
	rdrm_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.dec_s2       (dec_s2),
		.ram_rdata    (ram_rdata),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.frame_address(frame_address),
		.frame_length (frame_length),
		.size_word    (size_word)
	);

endmodule

[rtl/core/rdrm_checker.sv]
`timescale 1ns / 1ps
`include "rx_descriptor_ring_manager_macros.svh"
module rdrm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [2:0]                   status,
	input logic [rdrm_pkg::ADDR_W-1:0]  frame_address,
	input logic [rdrm_pkg::LEN_W-1:0]   frame_length,
	input logic [rdrm_pkg::WORD_W-1:0]  size_word
);

	logic acc;
	logic no_frame;
	logic not_posted;
	logic has_frame;

	assign acc = start && !busy;
	assign no_frame = (status == rdrm_pkg::ST_POSTED) || (status == rdrm_pkg::ST_FULL) ||
		(status == rdrm_pkg::ST_NOT_READY) || (status == rdrm_pkg::ST_EMPTY);
	assign not_posted = (status != rdrm_pkg::ST_POSTED);
	assign has_frame  = (frame_address != '0) || (frame_length != '0);

	// Every accepted item gives its result once it has passed the pipeline, and no result comes without one.
	`RDRM_ASSERT_IMP(a_result_follows, clk, arst_n, acc, ##3 done)
	`RDRM_ASSERT_IMP(a_result_has_item, clk, arst_n, done, $past(acc, 3))
	// Only a successful post carries a size word.
	`RDRM_ASSERT_IMP(a_size_on_post, clk, arst_n, done && not_posted, size_word == '0)
	// Results that consume nothing carry no frame.
	`RDRM_ASSERT_NEVER(a_no_frame, clk, arst_n, done && no_frame && has_frame)

endmodule

bind rx_descriptor_ring_manager rdrm_checker u_rdrm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.frame_address(frame_address),
	.frame_length (frame_length),
	.size_word    (size_word)
);

[dv/ring_result_checker.sv]
`timescale 1ns / 1ps
module ring_result_checker #(
	parameter int RING_DEPTH = rdrm_pkg::RING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         command,
	input  logic [rdrm_pkg::ADDR_W-1:0]  buffer_address,
	input  logic [rdrm_pkg::WORD_W-1:0]  desc_status,
	input  logic                         done,
	input  logic [2:0]                   status,
	input  logic [rdrm_pkg::SLOT_W-1:0]  slot,
	input  logic [rdrm_pkg::ADDR_W-1:0]  frame_address,
	input  logic [rdrm_pkg::LEN_W-1:0]   frame_length,
	input  logic [rdrm_pkg::WORD_W-1:0]  size_word,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [rdrm_pkg::BSIZE_W-1:0] cfg_data,
	output int                           mismatch_count,
	output int                           awaiting,
	output int                           results_seen
);

	typedef struct packed {
		rdrm_pkg::status_t             status;
		logic [rdrm_pkg::SLOT_W-1:0]   slot;
		logic [rdrm_pkg::ADDR_W-1:0]   address;
		logic [rdrm_pkg::LEN_W-1:0]    length;
		logic [rdrm_pkg::WORD_W-1:0]   size_word;
	} ring_result_t;

	// Shadow of the ring: one address per slot, both indices and the buffer size.
	logic [rdrm_pkg::ADDR_W-1:0]  posted_address [RING_DEPTH];
	int unsigned                  producer;
	int unsigned                  consumer;
	logic [rdrm_pkg::BSIZE_W-1:0] buffer_size_copy;
	ring_result_t                 awaited_results [$];
	ring_result_t                 want;

	function automatic int unsigned ring_step(int unsigned i);
		return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
	endfunction

	// Works out the result of one accepted item and moves the shadow ring on.
	function automatic ring_result_t ring_outcome(logic cmd, logic [rdrm_pkg::ADDR_W-1:0] addr,
			logic [rdrm_pkg::WORD_W-1:0] word);
		ring_result_t               r;
		logic [rdrm_pkg::LEN_W-1:0] len;
		r = '0;
		if (cmd == rdrm_pkg::CMD_POST) begin
			r.slot = rdrm_pkg::SLOT_W'(producer);
			if (ring_step(producer) == consumer) begin
				r.status = rdrm_pkg::ST_FULL;
			end else begin
				posted_address[producer] = addr;
				r.status = rdrm_pkg::ST_POSTED;
				r.size_word = rdrm_pkg::WORD_W'(buffer_size_copy);
				if (producer == RING_DEPTH - 1)
					r.size_word[rdrm_pkg::END_RING_BIT] = 1'b1;
				producer = ring_step(producer);
			end
		end else begin
			r.slot = rdrm_pkg::SLOT_W'(consumer);
			if (word[rdrm_pkg::OWN_BIT]) begin
				r.status = rdrm_pkg::ST_NOT_READY;
			end else if (producer == consumer) begin
				r.status = rdrm_pkg::ST_EMPTY;
			end else begin
				len = word[rdrm_pkg::LEN_W-1:0];
				r.address = posted_address[consumer];
				consumer = ring_step(consumer);
				if (len < rdrm_pkg::CRC_LEN || (word & rdrm_pkg::ERR_MASK) != '0) begin
					r.status = rdrm_pkg::ST_DROPPED;
				end else begin
					r.status = rdrm_pkg::ST_DELIVERED;
					r.length = len - rdrm_pkg::CRC_LEN;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// Results are compared before the item of the same edge is predicted; the
	// pipeline is three stages deep, so the two can never belong together.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			producer = 0;
			consumer = 0;
			buffer_size_copy = rdrm_pkg::BSIZE_RST;
			awaited_results.delete();
			mismatch_count = 0;
			awaiting = 0;
			results_seen = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result for slot %0d with no result awaited", slot);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("slot", 32'(want.slot), 32'(slot));
					check_field("frame_address", want.address, frame_address);
					check_field("frame_length", 32'(want.length), 32'(frame_length));
					check_field("size_word", want.size_word, size_word);
				end
			end
			if (cfg_valid && cfg_ready)
				buffer_size_copy = cfg_data;
			if (start && !busy)
				awaited_results.push_back(ring_outcome(command, buffer_address, desc_status));
			awaiting = awaited_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the receive ring manager. The checker beside the
// block watches every channel, predicts each result and counts mismatches;
// this module only shapes the traffic and reports the outcome.
module tb_top;

	// Far above the slowest correct run: about 650 items in bursts with random gaps,
	// plus a handful of drains of the three-stage pipeline.
	localparam int CYCLE_LIMIT = 200000;

	// Error bits of the written-back status word.
	localparam int RUNT_BIT   = 15;
	localparam int CRC_BIT    = 20;
	localparam int MAXLEN_BIT = 21;
	localparam int JABBER_BIT = 22;
	localparam int LENGTH_BIT = 23;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          command = rdrm_pkg::CMD_POST;
	logic [rdrm_pkg::ADDR_W-1:0]   buffer_address = '0;
	logic [rdrm_pkg::WORD_W-1:0]   desc_status = '0;
	logic                          cfg_valid = 1'b0;
	logic [rdrm_pkg::BSIZE_W-1:0]  cfg_data = '0;
	logic                          busy;
	logic                          done;
	logic [2:0]                    status;
	logic [rdrm_pkg::SLOT_W-1:0]   slot;
	logic [rdrm_pkg::ADDR_W-1:0]   frame_address;
	logic [rdrm_pkg::LEN_W-1:0]    frame_length;
	logic [rdrm_pkg::WORD_W-1:0]   size_word;
	logic                          cfg_ready;

	int mismatch_count;
	int awaiting;
	int results_seen;
	int cycle_count = 0;
	int burst_left = 0;
	int post_items = 0;
	int consume_items = 0;
	int size_settings = 1;
	int error_bits [5] = '{RUNT_BIT, CRC_BIT, MAXLEN_BIT, JABBER_BIT, LENGTH_BIT};

	rx_descriptor_ring_manager uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.buffer_address (buffer_address),
		.desc_status    (desc_status),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.frame_address  (frame_address),
		.frame_length   (frame_length),
		.size_word      (size_word),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	ring_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.buffer_address (buffer_address),
		.desc_status    (desc_status),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.frame_address  (frame_address),
		.frame_length   (frame_length),
		.size_word      (size_word),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting),
		.results_seen   (results_seen)
	);

	always #6 clk = ~clk;

	// Watchdog: a hung handshake or a result that never arrives ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one item and returns at the edge that accepted it. The sender works
	// in bursts; between bursts start drops for a random number of cycles. A gap
	// of zero leaves start high, so a burst can run straight into the next one.
	task automatic send_item(logic cmd, logic [rdrm_pkg::ADDR_W-1:0] addr,
			logic [rdrm_pkg::WORD_W-1:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		command <= cmd;
		buffer_address <= addr;
		desc_status <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd == rdrm_pkg::CMD_POST)
			post_items++;
		else
			consume_items++;
	endtask

	// Stops the traffic and waits until every predicted result has come back.
	// The first edge lets the checker record the last item before we look at
	// its count; the edges after the wait only add margin.
	task automatic wait_for_results();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only ever called with the block idle.
	task automatic write_buffer_size(logic [rdrm_pkg::BSIZE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		size_settings++;
	endtask

	// A written-back status word with random content. Most are clean frames;
	// some carry error bits, some have a length too short to hold the CRC,
	// and the OWN bit is set with the given likelihood in percent.
	function automatic logic [rdrm_pkg::WORD_W-1:0] random_status(int own_pct);
		logic [rdrm_pkg::WORD_W-1:0] word;
		word = $urandom;
		word = word & ~rdrm_pkg::ERR_MASK;
		if ($urandom_range(0, 99) < 12)
			word = word | ($urandom & rdrm_pkg::ERR_MASK);
		if ($urandom_range(0, 99) < 10)
			word[rdrm_pkg::LEN_W-1:0] = rdrm_pkg::LEN_W'($urandom_range(0, 5));
		word[rdrm_pkg::OWN_BIT] = ($urandom_range(0, 99) < own_pct);
		return word;
	endfunction

	task automatic run_traffic(int count, int post_pct, int own_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < post_pct)
				send_item(rdrm_pkg::CMD_POST, $urandom, $urandom);
			else
				send_item(rdrm_pkg::CMD_CONSUME, $urandom, random_status(own_pct));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the buffer size left at its reset value.
		// On an empty ring a descriptor still owned by the DMA engine reports
		// not ready, since that check comes first; a released one reports empty.
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, (32'd1 << rdrm_pkg::OWN_BIT) | 32'd64);
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'd64);
		// Address extremes, then the shortest deliverable frame (nothing left
		// once the CRC is taken off) and a frame one byte too short.
		send_item(rdrm_pkg::CMD_POST, '0, $urandom);
		send_item(rdrm_pkg::CMD_POST, '1, $urandom);
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'd4);
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'd3);
		wait_for_results();

		// Largest buffer size, then eight buffers for the consumes that follow.
		write_buffer_size('1);
		send_item(rdrm_pkg::CMD_POST, 32'hA5A5_A5A5, $urandom);
		send_item(rdrm_pkg::CMD_POST, 32'h5A5A_5A5A, $urandom);
		repeat (6) send_item(rdrm_pkg::CMD_POST, $urandom, $urandom);
		// An owned descriptor on a ring with buffers waiting changes nothing.
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, '1);
		// Longest length, zero length, each error bit alone, and every bit
		// set apart from OWN.
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'h0000_3FFF);
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'd0);
		foreach (error_bits[i])
			send_item(rdrm_pkg::CMD_CONSUME, $urandom, (32'd1 << error_bits[i]) | 32'd1000);
		send_item(rdrm_pkg::CMD_CONSUME, $urandom, 32'h7FFF_FFFF);
		wait_for_results();

		// Fill: more posts than the ring can hold, so it runs into ring full
		// several times and the producer passes the last slot with end of ring.
		write_buffer_size(rdrm_pkg::BSIZE_W'($urandom));
		run_traffic(515, 100, 0);
		wait_for_results();

		// Partial drain with a zero buffer size: mostly consumes, some of them
		// still owned by the DMA engine.
		write_buffer_size('0);
		run_traffic(90, 3, 5);
		wait_for_results();

		// Even mix of both commands on a well filled ring.
		write_buffer_size(rdrm_pkg::BSIZE_W'($urandom));
		run_traffic(25, 50, 15);
		wait_for_results();

		$display("Run sent %0d post and %0d consume items under %0d buffer size settings,",
			post_items, consume_items, size_settings);
		$display("filling the ring past its last slot and draining part of it; %0d results compared.",
			results_seen);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
